### src/sieve_prime_counter_macros.svh
// Assertion macros used by the checker file.
`ifndef SIEVE_PRIME_COUNTER_MACROS_SVH
`define SIEVE_PRIME_COUNTER_MACROS_SVH

// Overlapping implication, ignored while reset is high.
`define SPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sieve_prime_counter check failed");

// Next-cycle implication, ignored while reset is high.
`define SPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sieve_prime_counter check failed");

// Next-cycle implication that is also checked across reset.
`define SPC_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sieve_prime_counter reset check failed");

`endif

### src/spc_pkg.sv
package spc_pkg;

  localparam int TargetW = 16;
  localparam int CountW = 13;
  localparam int MapDepth = 8192;
  localparam int AddrW = $clog2(MapDepth);

  localparam logic [TargetW-1:0] TargetMax = 16'd65535;
  localparam logic [CountW-1:0] MaxPrimeCount = 13'd6542;

  typedef struct packed {
    logic idle;
    logic done;
  } spc_status_t;

  // Number of clear bits in one map byte.
  function automatic logic [3:0] zeros_in_byte(input logic [7:0] v);
    logic [3:0] z;
    z = 4'd0;
    for (int b = 0; b < 8; b++) begin
      z = z + {3'd0, ~v[b]};
    end
    return z;
  endfunction

  // Bits above position top are set, so they count as marked.
  function automatic logic [7:0] tail_mask(input logic [2:0] top);
    logic [7:0] m;
    for (int b = 0; b < 8; b++) begin
      m[b] = (b > int'(top));
    end
    return m;
  endfunction

endpackage

### src/spc_engine.sv
module spc_engine
  import spc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TargetW-1:0] target_in,
  input  logic               res_ack,
  output spc_status_t        status,
  output logic [CountW-1:0]  count
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StClear  = 4'd1;
  localparam logic [3:0] StSread  = 4'd2;
  localparam logic [3:0] StScheck = 4'd3;
  localparam logic [3:0] StMark   = 4'd4;
  localparam logic [3:0] StCrd    = 4'd5;
  localparam logic [3:0] StCacc   = 4'd6;
  localparam logic [3:0] StLacc   = 4'd7;
  localparam logic [3:0] StDone   = 4'd8;

  logic [3:0]         state;
  logic [TargetW-1:0] n;
  logic [AddrW-1:0]   k;
  logic [15:0]        i;
  logic [16:0]        j;

  logic [AddrW-1:0]   last_byte;
  logic               j_in_range;
  logic [16:0]        add_a, add_b, add_sum;

  logic [7:0]         map_mem [MapDepth];
  logic [7:0]         rd_q;
  logic [AddrW-1:0]   mem_addr;
  logic [7:0]         wmask, wdata;

  assign last_byte  = n[TargetW-1:3];
  // j is below the map size in bits when its byte index is not past the last byte.
  assign j_in_range = (j[16:3] <= {1'b0, last_byte});

  // The one adder shared by every phase.
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state)
      StClear, StCrd: begin
        add_a = {4'd0, k};
        add_b = 17'd1;
      end
      StScheck: begin
        add_a = {1'b0, i};
        add_b = 17'd1;
      end
      StMark: begin
        if (j_in_range) begin
          add_a = j;
          add_b = {1'b0, i};
        end else begin
          add_a = {1'b0, i};
          add_b = 17'd1;
        end
      end
      StCacc: begin
        add_a = {4'd0, count};
        add_b = {13'd0, zeros_in_byte(rd_q)};
      end
      StLacc: begin
        add_a = {4'd0, count};
        add_b = {13'd0, zeros_in_byte(rd_q | tail_mask(n[2:0]))};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  always_comb begin
    mem_addr = k;
    wmask    = 8'h00;
    wdata    = 8'h00;
    case (state)
      StClear: begin
        mem_addr = k;
        wmask    = 8'hff;
        // Byte zero starts with 0 and 1 marked.
        wdata    = (k == '0) ? 8'h03 : 8'h00;
      end
      StSread: mem_addr = i[15:3];
      StMark: begin
        mem_addr = j[15:3];
        wmask    = j_in_range ? (8'h01 << j[2:0]) : 8'h00;
        wdata    = 8'hff;
      end
      StCrd: mem_addr = k;
      default: mem_addr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 8; b++) begin
      if (wmask[b]) begin
        map_mem[mem_addr][b] <= wdata[b];
      end
    end
    rd_q <= map_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      case (state)
        StIdle: begin
          if (start) begin
            n     <= (target_in > TargetMax) ? TargetMax : target_in;
            k     <= '0;
            count <= '0;
            state <= StClear;
          end
        end
        StClear: begin
          k <= add_sum[AddrW-1:0];
          if (k == last_byte) begin
            i     <= 16'd2;
            state <= StSread;
          end
        end
        StSread: begin
          // Candidates run while i is below half the map size in bits.
          if (i[15:2] > {1'b0, last_byte}) begin
            k     <= '0;
            state <= StCrd;
          end else begin
            state <= StScheck;
          end
        end
        StScheck: begin
          if (!rd_q[i[2:0]]) begin
            j     <= {i, 1'b0};
            state <= StMark;
          end else begin
            i     <= add_sum[15:0];
            state <= StSread;
          end
        end
        StMark: begin
          if (j_in_range) begin
            j <= add_sum;
          end else begin
            i     <= add_sum[15:0];
            state <= StSread;
          end
        end
        StCrd: begin
          // The read of the last byte is issued here too; its count is masked.
          if (k == last_byte) begin
            state <= StLacc;
          end else begin
            k     <= add_sum[AddrW-1:0];
            state <= StCacc;
          end
        end
        StCacc: begin
          count <= add_sum[CountW-1:0];
          state <= StCrd;
        end
        StLacc: begin
          count <= add_sum[CountW-1:0];
          state <= StDone;
        end
        StDone: begin
          if (res_ack) begin
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign status.idle = (state == StIdle);
  assign status.done = (state == StDone);

endmodule

### src/sieve_prime_counter.sv
// Prime counter over a sieve of Eratosthenes.
// Input channel in_valid/in_ready carries target N; the output channel
// out_valid/out_ready returns prime_count, the number of primes p with
// 2 <= p <= N. Every transaction on the input gives exactly one result.
// One item is worked at a time on a shared adder and a byte-wide map
// memory of 8192 entries. The sequencer clears the map, reads and checks
// each sieve candidate below half the map size, marks every multiple of a
// candidate found clear and closes each run of marks in a further state,
// then reads and counts each map byte, masking the last one above N.
// in_ready is high only while the sequencer is idle.
// A finished result moves into an output register, so a new target is
// taken while that result still waits on out_ready. If the receiver
// stalls, the next result is held inside the sequencer until the output
// register frees. Synchronous reset empties the output register and
// returns the sequencer to idle; the map is rebuilt for every target.
module sieve_prime_counter
  import spc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TargetW-1:0] target,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CountW-1:0]  prime_count
);

  spc_status_t       status;
  logic [CountW-1:0] eng_count;
  logic              res_ack;

  assign in_ready = status.idle;
  assign res_ack  = status.done && (!out_valid || out_ready);

  spc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .target_in (target),
    .res_ack   (res_ack),
    .status    (status),
    .count     (eng_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      prime_count <= eng_count;
    end
  end

endmodule

### src/spc_checker.sv
`include "sieve_prime_counter_macros.svh"

module spc_checker
  import spc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CountW-1:0]  prime_count
);

  `SPC_ASSERT_RST(a_reset_empties_output, rst, !out_valid)
  `SPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SPC_ASSERT_NEXT(a_stalled_result_holds, out_valid && !out_ready, out_valid && $stable(prime_count))
  `SPC_ASSERT_NOW(a_count_in_range, out_valid, prime_count <= MaxPrimeCount)

endmodule

bind sieve_prime_counter spc_checker u_spc_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import spc_pkg::*;

  // Keeps its own composite map and the queue of prime counts still owed by the block.
  class prime_tally;
    bit [7:0] composite [MapDepth];
    logic [CountW-1:0] pending_counts [$];
    int failures;

    // Sieve over whole bytes covering n, then count the clear bits up to n.
    function logic [CountW-1:0] sieve_count(input logic [TargetW-1:0] n);
      int unsigned top;
      int unsigned nbytes;
      int unsigned nbits;
      int unsigned half;
      int unsigned count;
      top = n;
      if (top > TargetMax) begin
        top = TargetMax;
      end
      nbytes = (top >> 3) + 1;
      nbits = nbytes * 8;
      half = nbits / 2;
      count = 0;
      for (int unsigned k = 0; k < nbytes; k++) begin
        composite[k] = 8'h00;
      end
      composite[0][1:0] = 2'b11;
      for (int unsigned i = 2; i < half; i++) begin
        if (!composite[i >> 3][i % 8]) begin
          for (int unsigned j = 2 * i; j < nbits; j += i) begin
            composite[j >> 3][j % 8] = 1'b1;
          end
        end
      end
      for (int unsigned k = 0; k + 1 < nbytes; k++) begin
        count += 8 - $countones(composite[k]);
      end
      // The last byte only counts up to the target itself.
      for (int unsigned j = nbits - 8; j <= top; j++) begin
        if (!composite[j >> 3][j % 8]) begin
          count++;
        end
      end
      return count[CountW-1:0];
    endfunction

    function void note_target(input logic [TargetW-1:0] n);
      pending_counts.push_back(sieve_count(n));
    endfunction

    function void check_count(input logic [CountW-1:0] actual);
      logic [CountW-1:0] expected;
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected prime_count, expected none, actual %0d", $time, actual);
        failures++;
      end else begin
        expected = pending_counts.pop_front();
        if (actual !== expected) begin
          $display("%0t: prime_count mismatch, expected %0d, actual %0d",
                   $time, expected, actual);
          failures++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TargetW-1:0] target = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CountW-1:0]  prime_count;

  prime_tally book;

  logic [TargetW-1:0] corner_targets [21] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd9, 16'd15, 16'd16,
    16'd17, 16'd63, 16'd64, 16'd97, 16'd255, 16'd256, 16'd257, 16'd1000, 16'd4096,
    16'd65535
  };

  sieve_prime_counter DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .target      (target),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prime_count (prime_count)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap(input bit burst);
    if (burst) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Most targets stay small to keep the run short; a few reach a few thousand.
  function automatic logic [TargetW-1:0] random_target(input int idx);
    if (idx % 20 == 19) begin
      return $urandom_range(4096, 8191);
    end
    if (idx % 4 == 3) begin
      return $urandom_range(256, 4095);
    end
    return $urandom_range(0, 255);
  endfunction

  task automatic send_target(input logic [TargetW-1:0] n, input bit burst);
    int gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_target(n);
  endtask

  // Result side: sometimes waits for out_valid with ready low, so stalls land on a held result.
  initial begin : drain
    int gap;
    int taken;
    bit burst;
    bit hold_first;
    taken = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      burst = (taken / 12) % 3 == 2;
      gap = pick_gap(burst);
      hold_first = !burst && ($urandom_range(0, 1) == 1);
      if (hold_first) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (gap) @(posedge clk);
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      book.check_count(prime_count);
      taken++;
    end
  end

  initial begin
    book = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_targets[d]) begin
      send_target(corner_targets[d], 1'b0);
    end
    for (int r = 0; r < 80; r++) begin
      send_target(random_target(r), (r / 16) % 3 == 1);
    end
    in_valid <= 1'b0;
    while (book.pending_counts.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (book.failures == 0 && book.pending_counts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
